// File: rtl/lcw_pkg.sv
// Shared types and constants for the LED color and white mix unit.
package lcw_pkg;

	localparam int NSTAGE = 8;

	typedef logic [NSTAGE-1:0] stage_en_t;

	typedef struct packed {
		logic [7:0]  hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		logic [15:0] color_temp;
	} lcw_in_t;

	typedef struct packed {
		logic [11:0] red_duty;
		logic [11:0] green_duty;
		logic [11:0] blue_duty;
		logic [11:0] cold_duty;
		logic [11:0] warm_duty;
	} lcw_out_t;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_MIN_SAT  = 2'd0;
	localparam cfg_idx_t CFG_MIN_CBRI = 2'd1;
	localparam cfg_idx_t CFG_MIN_WBRI = 2'd2;

	localparam logic [6:0] RST_MIN_SAT  = 7'd20;
	localparam logic [6:0] RST_MIN_CBRI = 7'd10;
	localparam logic [7:0] RST_MIN_WBRI = 8'd10;
	localparam logic [6:0] PCT_FULL     = 7'd100;

	// reciprocal estimates, each low by at most one after the shift
	localparam logic [16:0] HUE_RECIP   = 17'd92880;    // 180*516, >>16 ~ /127
	localparam logic [14:0] PCT_RECIP   = 15'd25700;    // 100*257, >>16 ~ /255
	localparam logic [14:0] CH_RECIP    = 15'd26843;    // >>24 ~ /625
	localparam logic [22:0] WHITE_RECIP = 23'd4908534;  // >>32 ~ /875

	localparam logic [15:0] CT_WARM = 16'd3000;
	localparam logic [15:0] CT_COLD = 16'd6500;

endpackage

// File: rtl/lcw_color.sv
// Color path: hue/saturation/value scaling and six-sector RGB conversion.
module lcw_color (
	input  logic              clk,
	input  lcw_pkg::stage_en_t en,
	input  lcw_pkg::lcw_in_t  din,
	input  logic [6:0]        min_sat,
	input  logic [6:0]        min_bri,
	output logic [11:0]       red,
	output logic [11:0]       green,
	output logic [11:0]       blue
);
	import lcw_pkg::*;

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	localparam int KI_MAX = 0;
	localparam int KI_MIN = 1;
	localparam int KI_UP  = 2;
	localparam int KI_DN  = 3;
	localparam int NK     = 4;

	// stage 1: quotient estimates
	logic [24:0] hue_prod;
	logic [22:0] sat_prod, bri_prod;
	logic [7:0]  hue_s1, sat_s1, bri_s1;
	logic [8:0]  hq0_s1;
	logic [6:0]  sq0_s1, bq0_s1;

	assign hue_prod = 25'(din.hue) * 25'(HUE_RECIP);
	assign sat_prod = 23'(din.saturation) * 23'(PCT_RECIP);
	assign bri_prod = 23'(din.brightness) * 23'(PCT_RECIP);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hue_s1 <= din.hue;
			sat_s1 <= din.saturation;
			bri_s1 <= din.brightness;
			hq0_s1 <= hue_prod[24:16];
			sq0_s1 <= sat_prod[22:16];
			bq0_s1 <= bri_prod[22:16];
		end
	end

	// stage 2: corrected quotients, degrees and floored percents
	logic [15:0] h_rem;
	logic [14:0] s_rem, v_rem;
	logic [8:0]  h_deg0, h_deg;
	logic [6:0]  s_pct, v_pct;
	logic [8:0]  h_s2;
	logic [6:0]  s_s2, v_s2;

	always_comb begin
		h_rem  = 16'(hue_s1) * 16'd180 - 16'(hq0_s1) * 16'd127;
		h_deg0 = hq0_s1 + ((h_rem >= 16'd127) ? 9'd1 : 9'd0);
		h_deg  = (h_deg0 > 9'd0) ? h_deg0 - 9'd1 : 9'd0;
		// full circle wraps to zero degrees
		if (h_deg >= 9'd360)
			h_deg = 9'd0;
		s_rem = 15'(sat_s1) * 15'd100 - 15'(sq0_s1) * 15'd255;
		v_rem = 15'(bri_s1) * 15'd100 - 15'(bq0_s1) * 15'd255;
		s_pct = sq0_s1 + ((s_rem >= 15'd255) ? 7'd1 : 7'd0);
		v_pct = bq0_s1 + ((v_rem >= 15'd255) ? 7'd1 : 7'd0);
		if (s_pct < min_sat)
			s_pct = min_sat;
		if (v_pct < min_bri)
			v_pct = min_bri;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			h_s2 <= h_deg;
			s_s2 <= s_pct;
			v_s2 <= v_pct;
		end
	end

	// stage 3: sector, offset in sector, minimum term
	sector_t    sec;
	logic [8:0] h_base;
	logic [12:0] kmin;
	sector_t    sec_s3;
	logic [5:0] hm_s3;
	logic [6:0] s_s3, v_s3;
	logic [12:0] kmin_s3;

	always_comb begin
		if (h_s2 >= 9'd300) begin
			sec = SEC_MAG_RED;
			h_base = 9'd300;
		end else if (h_s2 >= 9'd240) begin
			sec = SEC_BLU_MAG;
			h_base = 9'd240;
		end else if (h_s2 >= 9'd180) begin
			sec = SEC_CYN_BLU;
			h_base = 9'd180;
		end else if (h_s2 >= 9'd120) begin
			sec = SEC_GRN_CYN;
			h_base = 9'd120;
		end else if (h_s2 >= 9'd60) begin
			sec = SEC_YEL_GRN;
			h_base = 9'd60;
		end else begin
			sec = SEC_RED_YEL;
			h_base = 9'd0;
		end
		kmin = 13'(PCT_FULL - s_s2) * 13'd60;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sec_s3  <= sec;
			hm_s3   <= 6'(h_s2 - h_base);
			s_s3    <= s_s2;
			v_s3    <= v_s2;
			kmin_s3 <= kmin;
		end
	end

	// stage 4: rising and falling terms, all scaled by v*255/600000 later
	logic [12:0] sh;
	logic [12:0] k_s4 [NK];
	logic [6:0]  v_s4;
	sector_t     sec_s4;

	assign sh = 13'(s_s3) * 13'(hm_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			k_s4[KI_MAX] <= 13'd6000;
			k_s4[KI_MIN] <= kmin_s3;
			k_s4[KI_UP]  <= kmin_s3 + sh;
			k_s4[KI_DN]  <= 13'd6000 - sh;
			v_s4         <= v_s3;
			sec_s4       <= sec_s3;
		end
	end

	// stage 5: v*K
	logic [19:0] p_s5 [NK];
	sector_t     sec_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < NK; i++)
				p_s5[i] <= 20'(v_s4) * 20'(k_s4[i]);
			sec_s5 <= sec_s4;
		end
	end

	// stage 6: round half up of 17*p/40000 -> z/625 with z = (17p+20000)>>6
	logic [23:0] y [NK];
	logic [17:0] z_s6 [NK];
	sector_t     sec_s6;

	always_comb begin
		for (int i = 0; i < NK; i++)
			y[i] = 24'(p_s5[i]) * 24'd17 + 24'd20000;
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < NK; i++)
				z_s6[i] <= y[i][23:6];
			sec_s6 <= sec_s5;
		end
	end

	// stage 7: quotient estimate
	logic [31:0] zq [NK];
	logic [7:0]  q0_s7 [NK];
	logic [17:0] z_s7 [NK];
	sector_t     sec_s7;

	always_comb begin
		for (int i = 0; i < NK; i++)
			zq[i] = 32'(z_s6[i]) * 32'(CH_RECIP);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < NK; i++) begin
				q0_s7[i] <= zq[i][31:24];
				z_s7[i]  <= z_s6[i];
			end
			sec_s7 <= sec_s6;
		end
	end

	// stage 8: correct, route by sector, scale to duty
	logic [17:0] zr [NK];
	logic [7:0]  ch [NK];
	logic [7:0]  r_c, g_c, b_c;
	logic [11:0] red_s8, green_s8, blue_s8;

	always_comb begin
		for (int i = 0; i < NK; i++) begin
			zr[i] = z_s7[i] - 18'(q0_s7[i]) * 18'd625;
			ch[i] = q0_s7[i] + ((zr[i] >= 18'd625) ? 8'd1 : 8'd0);
		end
		case (sec_s7)
			SEC_RED_YEL: begin
				r_c = ch[KI_MAX]; g_c = ch[KI_UP];  b_c = ch[KI_MIN];
			end
			SEC_YEL_GRN: begin
				r_c = ch[KI_DN];  g_c = ch[KI_MAX]; b_c = ch[KI_MIN];
			end
			SEC_GRN_CYN: begin
				r_c = ch[KI_MIN]; g_c = ch[KI_MAX]; b_c = ch[KI_UP];
			end
			SEC_CYN_BLU: begin
				r_c = ch[KI_MIN]; g_c = ch[KI_DN];  b_c = ch[KI_MAX];
			end
			SEC_BLU_MAG: begin
				r_c = ch[KI_UP];  g_c = ch[KI_MIN]; b_c = ch[KI_MAX];
			end
			default: begin
				r_c = ch[KI_MAX]; g_c = ch[KI_MIN]; b_c = ch[KI_DN];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			red_s8   <= 12'(r_c) * 12'd10;
			green_s8 <= 12'(g_c) * 12'd10;
			blue_s8  <= 12'(b_c) * 12'd10;
		end
	end

	assign red   = red_s8;
	assign green = green_s8;
	assign blue  = blue_s8;

endmodule

// File: rtl/lcw_white.sv
// White path: floored brightness split between warm and cold by temperature.
module lcw_white (
	input  logic              clk,
	input  lcw_pkg::stage_en_t en,
	input  lcw_pkg::lcw_in_t  din,
	input  logic [7:0]        min_wbri,
	output logic [11:0]       cold,
	output logic [11:0]       warm
);
	import lcw_pkg::*;

	// stage 1: floor, temperature zone and distances
	logic [15:0] dc_full, dw_full;
	logic [7:0]  bw_s1;
	logic        lo_s1, hi_s1;
	logic [11:0] dc_s1, dw_s1;

	assign dc_full = din.color_temp - CT_WARM;
	assign dw_full = CT_COLD - din.color_temp;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			bw_s1 <= (din.brightness < min_wbri) ? min_wbri : din.brightness;
			lo_s1 <= (din.color_temp <= CT_WARM);
			hi_s1 <= (din.color_temp >= CT_COLD);
			dc_s1 <= dc_full[11:0];
			dw_s1 <= dw_full[11:0];
		end
	end

	// stage 2: full duty
	logic [11:0] full_s2, dc_s2, dw_s2;
	logic        lo_s2, hi_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			full_s2 <= 12'(bw_s1) * 12'd10;
			dc_s2   <= dc_s1;
			dw_s2   <= dw_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
		end
	end

	// stage 3: blend numerators
	logic [23:0] nc_s3, nw_s3;
	logic [11:0] full_s3;
	logic        lo_s3, hi_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nc_s3   <= 24'(full_s2) * 24'(dc_s2);
			nw_s3   <= 24'(full_s2) * 24'(dw_s2);
			full_s3 <= full_s2;
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
		end
	end

	// stage 4: /3500 as >>2 then reciprocal estimate of /875
	logic [43:0] qc_prod, qw_prod;
	logic [21:0] zc_s4, zw_s4;
	logic [11:0] q0c_s4, q0w_s4, full_s4;
	logic        lo_s4, hi_s4;

	assign qc_prod = 44'(nc_s3[23:2]) * 44'(WHITE_RECIP);
	assign qw_prod = 44'(nw_s3[23:2]) * 44'(WHITE_RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			zc_s4   <= nc_s3[23:2];
			zw_s4   <= nw_s3[23:2];
			q0c_s4  <= qc_prod[43:32];
			q0w_s4  <= qw_prod[43:32];
			full_s4 <= full_s3;
			lo_s4   <= lo_s3;
			hi_s4   <= hi_s3;
		end
	end

	// stage 5: correct estimate, select by zone
	logic [21:0] rc, rw;
	logic [11:0] qc, qw;
	logic [11:0] cold_s5, warm_s5, cold_s6, warm_s6, cold_s7, warm_s7, cold_s8, warm_s8;

	always_comb begin
		rc = zc_s4 - 22'(q0c_s4) * 22'd875;
		rw = zw_s4 - 22'(q0w_s4) * 22'd875;
		qc = q0c_s4 + ((rc >= 22'd875) ? 12'd1 : 12'd0);
		qw = q0w_s4 + ((rw >= 22'd875) ? 12'd1 : 12'd0);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			cold_s5 <= hi_s4 ? full_s4 : (lo_s4 ? 12'd0 : qc);
			warm_s5 <= lo_s4 ? full_s4 : (hi_s4 ? 12'd0 : qw);
		end
	end

	// align with the color path
	always_ff @(posedge clk) begin
		if (en[5]) begin
			cold_s6 <= cold_s5;
			warm_s6 <= warm_s5;
		end
		if (en[6]) begin
			cold_s7 <= cold_s6;
			warm_s7 <= warm_s6;
		end
		if (en[7]) begin
			cold_s8 <= cold_s7;
			warm_s8 <= warm_s7;
		end
	end

	assign cold = cold_s8;
	assign warm = warm_s8;

endmodule

// File: rtl/led_color_and_white_mix_unit.sv
// Top level of the LED color and white mix unit: config, pipeline control, output select.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  lcw_in_t  in_data
//   out      out        out_valid/ out_stall lcw_out_t out_data
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// Eight register stages; an accepted request passes through them in order, and its
// result is valid in the last one; one request can be accepted every cycle unless a stalled output has filled them.
// The last stage is the output register. Each stage loads when it is empty or
// the stage after it moves, so bubbles close up and a stalled output holds.
// Reset clears the valid bits and loads the floor registers with 20, 10, 10.
module led_color_and_white_mix_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lcw_pkg::lcw_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output lcw_pkg::lcw_out_t out_data,
	input  logic              cfg_we,
	input  lcw_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]        cfg_data
);
	import lcw_pkg::*;

	logic [6:0] min_sat_q, min_cbri_q;
	logic [7:0] min_wbri_q;
	logic [6:0] min_sat, min_cbri;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sat_q  <= RST_MIN_SAT;
			min_cbri_q <= RST_MIN_CBRI;
			min_wbri_q <= RST_MIN_WBRI;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_SAT:  min_sat_q  <= cfg_data[6:0];
				CFG_MIN_CBRI: min_cbri_q <= cfg_data[6:0];
				CFG_MIN_WBRI: min_wbri_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// percent floors above full scale act as full scale
	assign min_sat  = (min_sat_q > PCT_FULL) ? PCT_FULL : min_sat_q;
	assign min_cbri = (min_cbri_q > PCT_FULL) ? PCT_FULL : min_cbri_q;

	stage_en_t          en;
	logic [NSTAGE-1:0]  vld_q;
	logic [NSTAGE-1:0]  color_q;

	always_comb begin
		en[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall;
		for (int k = NSTAGE - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign in_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTAGE; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// mode travels beside the data: zero temperature means color mode
	always_ff @(posedge clk) begin
		if (en[0])
			color_q[0] <= (in_data.color_temp == 16'd0);
		for (int k = 1; k < NSTAGE; k++)
			if (en[k])
				color_q[k] <= color_q[k-1];
	end

	logic [11:0] red, green, blue, cold, warm;

	lcw_color u_color (
		.clk     (clk),
		.en      (en),
		.din     (in_data),
		.min_sat (min_sat),
		.min_bri (min_cbri),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

	lcw_white u_white (
		.clk      (clk),
		.en       (en),
		.din      (in_data),
		.min_wbri (min_wbri_q),
		.cold     (cold),
		.warm     (warm)
	);

	assign out_valid = vld_q[NSTAGE-1];

	always_comb begin
		if (color_q[NSTAGE-1]) begin
			out_data.red_duty   = red;
			out_data.green_duty = green;
			out_data.blue_duty  = blue;
			out_data.cold_duty  = 12'd0;
			out_data.warm_duty  = 12'd0;
		end else begin
			out_data.red_duty   = 12'd0;
			out_data.green_duty = 12'd0;
			out_data.blue_duty  = 12'd0;
			out_data.cold_duty  = cold;
			out_data.warm_duty  = warm;
		end
	end

endmodule
